// ===== design/psf_pkg.sv =====
// package: sample formats, format tags, register indexes and latency
`timescale 1ns / 1ps
package psf_pkg;

   localparam logic [15:0] TAG_INT_PCM    = 16'h0001;
   localparam logic [15:0] TAG_IEEE_FLOAT = 16'h0003;

   localparam logic [7:0] CSR_FORMAT_TAG      = 8'd0;
   localparam logic [7:0] CSR_BITS_PER_SAMPLE = 8'd1;

   localparam logic [15:0] RESET_FORMAT_TAG      = TAG_INT_PCM;
   localparam logic [7:0]  RESET_BITS_PER_SAMPLE = 8'd16;

   localparam int unsigned LATENCY = 4;

   typedef enum logic [2:0] {
      FMT_U8,
      FMT_S16,
      FMT_S24,
      FMT_S32,
      FMT_F32,
      FMT_F64,
      FMT_NONE
   } fmt_type;

endpackage

// ===== design/psf_convert.sv =====
// four-stage conversion pipeline from raw sample bytes to a single-precision pattern
`timescale 1ns / 1ps
module psf_convert (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  psf_pkg::fmt_type in_fmt,
   input  logic [63:0]      in_raw,
   output logic             out_valid,
   output logic [31:0]      out_value,
   output logic             out_known
);
   import psf_pkg::*;

   // stage 1: captured item
   logic        v1_ff;
   fmt_type     fmt1_ff;
   logic [63:0] raw1_ff;

   // stage 2: unpacked fields
   logic        v2_ff, v2_in;
   logic        spec2_ff, spec2_in;
   logic [31:0] specval2_ff, specval2_in;
   logic        known2_ff, known2_in;
   logic        f64_2_ff, f64_2_in;
   logic        sign2_ff, sign2_in;
   logic [31:0] mag2_ff, mag2_in;
   logic [4:0]  k2_ff, k2_in;
   logic [52:0] sig2_ff, sig2_in;
   logic [5:0]  sh2_ff, sh2_in;
   logic        sub2_ff, sub2_in;
   logic [7:0]  fe2_ff, fe2_in;

   // stage 3: aligned significand and round decision
   logic        v3_ff, v3_in;
   logic        spec3_ff, spec3_in;
   logic [31:0] specval3_ff, specval3_in;
   logic        known3_ff, known3_in;
   logic        sign3_ff, sign3_in;
   logic [30:0] base3_ff, base3_in;
   logic        inc3_ff, inc3_in;

   // output
   logic        v4_ff;
   logic [31:0] value4_ff, value4_in;
   logic        known4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      fmt1_ff     <= in_fmt;
      raw1_ff     <= in_raw;
      spec2_ff    <= spec2_in;
      specval2_ff <= specval2_in;
      known2_ff   <= known2_in;
      f64_2_ff    <= f64_2_in;
      sign2_ff    <= sign2_in;
      mag2_ff     <= mag2_in;
      k2_ff       <= k2_in;
      sig2_ff     <= sig2_in;
      sh2_ff      <= sh2_in;
      sub2_ff     <= sub2_in;
      fe2_ff      <= fe2_in;
      spec3_ff    <= spec3_in;
      specval3_ff <= specval3_in;
      known3_ff   <= known3_in;
      sign3_ff    <= sign3_in;
      base3_ff    <= base3_in;
      inc3_ff     <= inc3_in;
      value4_ff   <= value4_in;
      known4_ff   <= known3_ff;
   end

   // stage 2: sign and magnitude for pcm, field split and special cases for double
   logic signed [32:0] sval;
   logic [10:0]        ex;
   logic signed [12:0] fe;

   always_comb begin
      v2_in       = v1_ff;
      spec2_in    = 1'b0;
      specval2_in = 32'h0;
      known2_in   = 1'b1;
      f64_2_in    = 1'b0;
      sign2_in    = 1'b0;
      k2_in       = 5'd0;
      sval        = 33'sd0;
      ex          = raw1_ff[62:52];
      fe          = $signed({2'b00, ex}) - 13'sd896;
      sig2_in     = {1'b1, raw1_ff[51:0]};
      sh2_in      = 6'd29;
      sub2_in     = 1'b0;
      fe2_in      = fe[7:0];
      case (fmt1_ff)
         FMT_U8: begin
            sval  = $signed({25'd0, raw1_ff[7:0]}) - 33'sd128;
            k2_in = 5'd7;
         end
         FMT_S16: begin
            sval  = {{17{raw1_ff[15]}}, raw1_ff[15:0]};
            k2_in = 5'd15;
         end
         FMT_S24: begin
            sval  = {{9{raw1_ff[23]}}, raw1_ff[23:0]};
            k2_in = 5'd23;
         end
         FMT_S32: begin
            sval  = {raw1_ff[31], raw1_ff[31:0]};
            k2_in = 5'd31;
         end
         FMT_F32: begin
            spec2_in    = 1'b1;
            specval2_in = raw1_ff[31:0];
         end
         FMT_F64: begin
            f64_2_in = 1'b1;
            sign2_in = raw1_ff[63];
            if (ex == 11'h7FF) begin
               spec2_in = 1'b1;
               if (raw1_ff[51:0] != 52'd0) begin
                  // quiet nan, top payload bits kept
                  specval2_in = {raw1_ff[63], 31'h7FC00000 | {8'd0, raw1_ff[51:29]}};
               end else begin
                  specval2_in = {raw1_ff[63], 31'h7F800000};
               end
            end else if (ex == 11'd0) begin
               spec2_in    = 1'b1;
               specval2_in = {raw1_ff[63], 31'd0};
            end else if (fe >= 13'sd255) begin
               spec2_in    = 1'b1;
               specval2_in = {raw1_ff[63], 31'h7F800000};
            end else if (fe <= -13'sd30) begin
               spec2_in    = 1'b1;
               specval2_in = {raw1_ff[63], 31'd0};
            end else if (fe < 13'sd1) begin
               sub2_in = 1'b1;
               sh2_in  = 6'(13'sd30 - fe);
            end
         end
         default: begin
            spec2_in  = 1'b1;
            known2_in = 1'b0;
         end
      endcase
      if (!f64_2_in) begin
         sign2_in = sval[32];
      end
      mag2_in = sval[32] ? 32'(-sval) : sval[31:0];
   end

   // stage 3: normalise the pcm magnitude, align the double significand
   logic [31:0]  n;
   logic [4:0]   cnt;
   logic [116:0] ext;
   logic [52:0]  q;
   logic         g, s;
   logic [30:0]  base;

   always_comb begin
      n   = mag2_ff;
      cnt = 5'd0;
      if (n[31:16] == 16'd0) begin n = n << 16; cnt = cnt + 5'd16; end
      if (n[31:24] == 8'd0)  begin n = n << 8;  cnt = cnt + 5'd8;  end
      if (n[31:28] == 4'd0)  begin n = n << 4;  cnt = cnt + 5'd4;  end
      if (n[31:30] == 2'd0)  begin n = n << 2;  cnt = cnt + 5'd2;  end
      if (n[31] == 1'b0)     begin n = n << 1;  cnt = cnt + 5'd1;  end
      ext = {sig2_ff, 64'd0} >> sh2_ff;
      q   = ext[116:64];
      if (f64_2_ff) begin
         g    = ext[63];
         s    = |ext[62:0];
         base = sub2_ff ? {8'd0, q[22:0]} : {fe2_ff, q[22:0]};
      end else begin
         g    = n[7];
         s    = |n[6:0];
         base = {8'(9'd158 - {4'd0, cnt} - {4'd0, k2_ff}), n[30:8]};
      end
      v3_in       = v2_ff;
      known3_in   = known2_ff;
      sign3_in    = sign2_ff;
      base3_in    = base;
      inc3_in     = g & (s | base[0]);
      spec3_in    = spec2_ff | (!f64_2_ff && mag2_ff == 32'd0);
      specval3_in = spec2_ff ? specval2_ff : 32'd0;
   end

   // stage 4: round and pack, carry may step into the exponent or to infinity
   assign value4_in = spec3_ff ? specval3_ff : {sign3_ff, base3_ff + {30'd0, inc3_ff}};

   assign out_valid = v4_ff;
   assign out_value = value4_ff;
   assign out_known = known4_ff;

endmodule

// ===== design/pcm_sample_to_float.sv =====
// top level: register port, format decode and conversion pipeline
`timescale 1ns / 1ps
// pcm_sample_to_float turns the raw little-endian bytes of one wav sample into an
// ieee-754 single, in [-1, 1] for pcm. format follows from format_tag (register 0)
// and bits_per_sample (register 1): unsigned 8-bit, signed 16/24/32-bit pcm,
// float32 passed through, float64 narrowed with round to nearest even. any other
// pair gives +0.0 with rsp_format_known low. a sample is taken on every clock edge
// where start is high; busy is always low, so one sample per cycle is sustained.
// each result is shown for one cycle, marked by rsp_strobe; the receiver cannot
// stall, so results are never held back. the pipeline has four stages: decode,
// field split, normalise or align, round and pack. the user must write registers
// only while no sample is in flight; the block itself does not enforce this.
module pcm_sample_to_float (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_sample_bytes,
   output logic        rsp_strobe,
   output logic [31:0] rsp_value_bits,
   output logic        rsp_format_known,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import psf_pkg::*;

   logic [15:0] format_tag_ff;
   logic [7:0]  bits_per_sample_ff;
   fmt_type     fmt;

   // pipeline never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // register writes, unused indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         format_tag_ff      <= RESET_FORMAT_TAG;
         bits_per_sample_ff <= RESET_BITS_PER_SAMPLE;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FORMAT_TAG) begin
            format_tag_ff <= csr_wdata;
         end
         if (csr_index == CSR_BITS_PER_SAMPLE) begin
            bits_per_sample_ff <= csr_wdata[7:0];
         end
      end
   end

   // tag and depth to a sample format
   always_comb begin
      fmt = FMT_NONE;
      if (format_tag_ff == TAG_INT_PCM) begin
         case (bits_per_sample_ff)
            8'd8:    fmt = FMT_U8;
            8'd16:   fmt = FMT_S16;
            8'd24:   fmt = FMT_S24;
            8'd32:   fmt = FMT_S32;
            default: fmt = FMT_NONE;
         endcase
      end else if (format_tag_ff == TAG_IEEE_FLOAT) begin
         case (bits_per_sample_ff)
            8'd32:   fmt = FMT_F32;
            8'd64:   fmt = FMT_F64;
            default: fmt = FMT_NONE;
         endcase
      end
   end

   psf_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_fmt    (fmt),
      .in_raw    (req_sample_bytes),
      .out_valid (rsp_strobe),
      .out_value (rsp_value_bits),
      .out_known (rsp_format_known)
   );

endmodule

// ===== design/psf_checker.sv =====
// port checker for pcm_sample_to_float and its bind
`timescale 1ns / 1ps
module psf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [31:0] rsp_value_bits,
   input logic        rsp_format_known
);
   import psf_pkg::*;

   // each transfer gives a result after the pipeline latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("result missing after transfer");

   // no result without a transfer
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 4))
      else $error("result without transfer");

   // unknown format gives +0.0
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_format_known) |-> (rsp_value_bits == 32'd0))
      else $error("unknown format not zero");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

bind pcm_sample_to_float psf_checker u_psf_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_value_bits   (rsp_value_bits),
   .rsp_format_known (rsp_format_known)
);
